### sv/bloom_filter_engine_unit_assert.svh
// assertion macros for the checker file
`ifndef BLOOM_FILTER_ENGINE_UNIT_ASSERT_SVH
`define BLOOM_FILTER_ENGINE_UNIT_ASSERT_SVH

// property checked only while out of reset
`define BFE_ASSERT_RUN(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("bloom filter check failed");

// property checked at every edge, reset included
`define BFE_ASSERT_ANY(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("bloom filter reset check failed");

`endif

### sv/bfe_pkg.sv
package bfe_pkg;

    localparam int unsigned DEF_MAX_BITS   = 65536;
    localparam int unsigned DEF_MAX_HASHES = 16;

    localparam logic [31:0] MM_MUL = 32'h5bd1e995;

    localparam int unsigned NB_W       = 17;
    localparam int unsigned NH_W       = 5;
    localparam int unsigned CFG_W      = 17;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned SEED_W     = 6;
    localparam int unsigned CNT_W      = 5;
    localparam int unsigned KEY_W      = 64;
    localparam int unsigned COUNT_W    = 32;
    localparam int unsigned HASH_STEPS = 8;
    localparam int unsigned MOD_STEPS  = 32;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_QUERY  = 2'd1,
        MODE_CLEAR  = 2'd2
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_BITS   = 2'd0,
        CFG_HASH_COUNT = 2'd1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_HASH,
        ST_MOD,
        ST_RD,
        ST_CHK,
        ST_CLR,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic             accept;
        logic             hash_step;
        logic             mod_step;
        logic             mem_rd;
        logic             check;
        logic             sweep;
        logic             finish;
        logic [CNT_W-1:0] step;
    } t_cmd;

    typedef struct packed {
        logic no_hashes;
        logic seed_last;
        logic sweep_last;
        logic out_free;
    } t_status;

endpackage

### sv/bloom_filter_engine_unit.sv
// Bloom filter over 64-bit keys with seeded 32-bit MurmurHash2 positions.
// One item at a time: an insert or query, for each hash in use, mixes the
// key on one shared 32x32 multiplier, takes a one-bit-per-cycle remainder
// by num_bits, then reads and checks or writes one 64-bit word of the bit
// store; a clear sweeps the store one word a cycle; any other mode goes
// straight to its result.
// The last cycle of an item waits while the previous result is still held.
// After reset the store is swept the same way with input stall held high;
// configuration writes are taken at any time but belong between items.
// Each item gives one result, held in an output register so the next
// item can be accepted while it waits.
module bloom_filter_engine_unit
    import bfe_pkg::*;
#(
    parameter int unsigned MAX_BITS   = DEF_MAX_BITS,
    parameter int unsigned MAX_HASHES = DEF_MAX_HASHES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_mode,
    input  logic [KEY_W-1:0]     i_key,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_maybe_present,
    output logic [COUNT_W-1:0]   o_element_count
);

    t_cmd    cmd;
    t_status status;

    // sequencing
    bfe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // hashing, store and counters
    bfe_datapath #(
        .MAX_BITS   (MAX_BITS),
        .MAX_HASHES (MAX_HASHES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_mode          (i_mode),
        .i_key           (i_key),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_maybe_present (o_maybe_present),
        .o_element_count (o_element_count),
        .i_cmd           (cmd),
        .o_status        (status)
    );

endmodule

### sv/bfe_ram.sv
module bfe_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 1024,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### sv/bfe_ctrl.sv
module bfe_ctrl
    import bfe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_mode,
    output logic       o_in_stall,
    input  t_status    i_status,
    output t_cmd       o_cmd
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                if (i_status.sweep_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_mode)
                        MODE_INSERT, MODE_QUERY:
                            n_state = i_status.no_hashes ? ST_DONE : ST_HASH;
                        MODE_CLEAR: n_state = ST_CLR;
                        default:    n_state = ST_DONE;
                    endcase
                end
            end
            ST_HASH: begin
                if (r_cnt == CNT_W'(HASH_STEPS - 1)) n_state = ST_MOD;
            end
            ST_MOD: begin
                if (r_cnt == CNT_W'(MOD_STEPS - 1)) n_state = ST_RD;
            end
            ST_RD:  n_state = ST_CHK;
            ST_CHK: n_state = i_status.seed_last ? ST_DONE : ST_HASH;
            ST_CLR: begin
                if (i_status.sweep_last) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_INIT;
        endcase
    end

    // step counter restarts on every state change
    always_comb begin
        n_cnt = (n_state != r_state) ? '0 : r_cnt + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // commands to the datapath
    always_comb begin
        o_cmd           = '0;
        o_cmd.step      = r_cnt;
        o_in_stall      = 1'b1;
        case (r_state)
            ST_INIT: o_cmd.sweep = 1'b1;
            ST_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
            end
            ST_HASH: o_cmd.hash_step = 1'b1;
            ST_MOD:  o_cmd.mod_step  = 1'b1;
            ST_RD:   o_cmd.mem_rd    = 1'b1;
            ST_CHK:  o_cmd.check     = 1'b1;
            ST_CLR:  o_cmd.sweep     = 1'b1;
            ST_DONE: o_cmd.finish    = i_status.out_free;
            default: o_cmd.sweep     = 1'b0;
        endcase
    end

endmodule

### sv/bfe_datapath.sv
module bfe_datapath
    import bfe_pkg::*;
#(
    parameter int unsigned MAX_BITS   = DEF_MAX_BITS,
    parameter int unsigned MAX_HASHES = DEF_MAX_HASHES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic [1:0]           i_mode,
    input  logic [KEY_W-1:0]     i_key,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output logic                 o_maybe_present,
    output logic [COUNT_W-1:0]   o_element_count,
    input  t_cmd                 i_cmd,
    output t_status              o_status
);

    localparam int unsigned DEPTH = (MAX_BITS + 63) / 64;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned MW    = $clog2(MAX_BITS + 1);

    // configuration
    logic [NB_W-1:0] r_num_bits;
    logic [NH_W-1:0] r_hash_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_bits   <= NB_W'(65536);
            r_hash_count <= NH_W'(7);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_NUM_BITS)   r_num_bits   <= i_cfg_data[NB_W-1:0];
            if (i_cfg_idx == CFG_HASH_COUNT) r_hash_count <= i_cfg_data[NH_W-1:0];
        end
    end

    // effective modulus and hash count
    logic [31:0]       m_full;
    logic [MW-1:0]     m;
    logic [SEED_W-1:0] eff_k;

    always_comb begin
        if (r_num_bits == '0)
            m_full = 32'd1;
        else if ({15'b0, r_num_bits} > 32'(MAX_BITS))
            m_full = 32'(MAX_BITS);
        else
            m_full = {15'b0, r_num_bits};
        m = m_full[MW-1:0];
        if ({1'b0, r_hash_count} > SEED_W'(MAX_HASHES))
            eff_k = SEED_W'(MAX_HASHES);
        else
            eff_k = {1'b0, r_hash_count};
    end

    // item registers
    logic [KEY_W-1:0]  r_key;
    logic [1:0]        r_mode;
    logic [SEED_W-1:0] r_seed;
    logic              r_present;
    logic [31:0]       r_k, r_h, r_div;
    logic [MW-1:0]     r_rem;
    logic [COUNT_W-1:0] r_count;
    logic [AW-1:0]     r_sweep_addr;

    // shared multiplier, operand picked by the mix step
    logic [31:0] mul_a, mul_p;

    always_comb begin
        case (i_cmd.step[2:0])
            3'd0:    mul_a = r_key[31:0];
            3'd1:    mul_a = r_k ^ (r_k >> 24);
            3'd2:    mul_a = {{(32-SEED_W){1'b0}}, r_seed} ^ 32'd8;
            3'd3:    mul_a = r_key[63:32];
            3'd4:    mul_a = r_k ^ (r_k >> 24);
            3'd5:    mul_a = r_h;
            3'd6:    mul_a = r_h ^ (r_h >> 13);
            default: mul_a = r_h;
        endcase
    end

    assign mul_p = mul_a * MM_MUL;

    // one restoring remainder bit per step
    logic [MW:0] rem_t, rem_d;

    always_comb begin
        rem_t = {r_rem, r_div[31]};
        rem_d = rem_t - {1'b0, m};
    end

    // bit store
    logic [63:0]   rdata;
    logic [AW-1:0] word;
    logic          bit_set;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [63:0]   mem_wdata;

    assign word    = r_rem[6+AW-1:6];
    assign bit_set = rdata[r_rem[5:0]];

    always_comb begin
        mem_we    = i_cmd.sweep || (i_cmd.check && r_mode == MODE_INSERT);
        mem_waddr = i_cmd.sweep ? r_sweep_addr : word;
        mem_wdata = i_cmd.sweep ? 64'd0 : (rdata | (64'd1 << r_rem[5:0]));
    end

    bfe_ram #(
        .WIDTH (64),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (word),
        .o_rdata (rdata)
    );

    // hashing, remainder and probe
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_key     <= i_key;
            r_mode    <= i_mode;
            r_seed    <= '0;
            r_present <= 1'b1;
        end
        if (i_cmd.hash_step) begin
            case (i_cmd.step[2:0])
                3'd2, 3'd5: r_h <= mul_p ^ r_k;
                3'd6:       r_h <= mul_p;
                3'd7: begin
                    r_div <= r_h ^ (r_h >> 15);
                    r_rem <= '0;
                end
                default:    r_k <= mul_p;
            endcase
        end
        if (i_cmd.mod_step) begin
            r_rem <= (rem_t >= {1'b0, m}) ? rem_d[MW-1:0] : rem_t[MW-1:0];
            r_div <= r_div << 1;
        end
        if (i_cmd.check) begin
            r_present <= r_present & bit_set;
            r_seed    <= r_seed + 1'b1;
        end
    end

    // sweep address for clearing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep_addr <= '0;
        end else if (i_cmd.sweep) begin
            r_sweep_addr <= (r_sweep_addr == AW'(DEPTH - 1)) ? '0 : r_sweep_addr + 1'b1;
        end
    end

    // element count and output register
    logic [COUNT_W-1:0] n_count;

    always_comb begin
        n_count = r_count;
        case (r_mode)
            MODE_INSERT: if (r_count != '1) n_count = r_count + 1'b1;
            MODE_CLEAR:  n_count = '0;
            default:     n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            o_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_count     <= n_count;
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_maybe_present <= (r_mode == MODE_QUERY) && r_present;
            o_element_count <= n_count;
        end
    end

    // status to the controller
    always_comb begin
        o_status.no_hashes  = (eff_k == '0);
        o_status.seed_last  = ((r_seed + 1'b1) == eff_k);
        o_status.sweep_last = (r_sweep_addr == AW'(DEPTH - 1));
        o_status.out_free   = !o_out_valid || !i_out_stall;
    end

endmodule

### sv/bfe_checker.sv
`include "bloom_filter_engine_unit_assert.svh"

module bfe_checker
    import bfe_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input logic [1:0]           i_mode,
    input logic [KEY_W-1:0]     i_key,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic                 o_maybe_present,
    input logic [COUNT_W-1:0]   o_element_count
);

    property p_out_hold;
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_element_count)
            && $stable(o_maybe_present);
    endproperty

    property p_in_hold;
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_mode) && $stable(i_key);
    endproperty

    // a stalled result holds
    `BFE_ASSERT_RUN(a_out_hold, p_out_hold)

    // a stalled input item holds
    `BFE_ASSERT_RUN(a_in_hold, p_in_hold)

    // one item in flight: busy right after an accept
    `BFE_ASSERT_RUN(a_busy_after_accept, i_in_valid && !o_in_stall |=> o_in_stall)

    // reset starts the clearing sweep with no result pending
    `BFE_ASSERT_ANY(a_reset_sweep, !i_rst_n |=> o_in_stall && !o_out_valid)

endmodule

bind bloom_filter_engine_unit bfe_checker u_chk (.*);
